[rtl/cqs_pkg.sv]
`timescale 1ns / 1ps

package cqs_pkg;

  // Ring geometry. One slot always stays empty, so the queue holds DEPTH-1 words.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int CNT_W  = 4;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_SRCH = 2'd2,
    CMD_CLR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN
  } state_t;

  // Which source the result register loads from.
  typedef enum logic [1:0] {
    LD_NONE,
    LD_SIMPLE,
    LD_DEQ,
    LD_SRCH
  } load_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_ready;
    logic    enq;
    logic    deq_rd;
    logic    clr;
    logic    srch_start;
    logic    srch_step;
    load_t   ld;
    status_t st;
  } ctl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_valid;
    logic empty;
    logic full;
    logic scan_hit;
    logic scan_last;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] item_count(logic [IDX_W-1:0] h, logic [IDX_W-1:0] t);
    logic [IDX_W:0] diff;
    if (t >= h) begin
      diff = {1'b0, t} - {1'b0, h};
    end else begin
      diff = (IDX_W + 1)'(DEPTH) - ({1'b0, h} - {1'b0, t});
    end
    return CNT_W'(diff);
  endfunction

endpackage

[rtl/circular_queue_with_search_unit.sv]
`timescale 1ns / 1ps

// Channel  Handshake              Word fields
// input    in_valid / in_ready    cmd[1:0], value[31:0] signed
// output   out_valid / out_ready  status[1:0], data[31:0] signed, found, count[3:0]
//
// Enqueue, clear, any failed command and a search of an empty ring finish in the
// cycle they are accepted; the result word is registered at that edge.
// A dequeue loads the head word in S_DEQ. A search makes one compare per occupied
// entry up to the first hit, at most DEPTH-1 compares, paced by the RAM read port.
// Reset zeroes head, tail and the result valid; slot contents are not cleared.
// A new word is taken only while idle with the result register empty or draining.

module circular_queue_with_search_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        cmd,
  input  logic signed [cqs_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [cqs_pkg::DATA_W-1:0] data,
  output logic                              found,
  output logic [cqs_pkg::CNT_W-1:0]         count
);

  // Commands flow from the controller; status flows back from the datapath.
  cqs_pkg::ctl_t     ctl;
  cqs_pkg::dp_stat_t stat;

  cqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .out_ready(out_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // The datapath owns the ring indices, the slot RAM, the search pointer and
  // the result register.
  cqs_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .value    (value),
    .out_ready(out_ready),
    .stat     (stat),
    .out_valid(out_valid),
    .status   (status),
    .data     (data),
    .found    (found),
    .count    (count)
  );

  assign in_ready = ctl.in_ready;

endmodule

[rtl/cqs_ram.sv]
`timescale 1ns / 1ps

module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cqs_ctrl.sv]
`timescale 1ns / 1ps

module cqs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         cmd,
  input  logic               out_ready,
  input  cqs_pkg::dp_stat_t  stat,
  output cqs_pkg::ctl_t      ctl
);

  cqs_pkg::state_t state;
  cqs_pkg::state_t state_next;
  logic            free;

  // The result register can take a new word if it is empty or drains this cycle.
  assign free = !stat.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cqs_pkg::S_IDLE: begin
        if (in_valid && free) begin
          if (cqs_pkg::cmd_t'(cmd) == cqs_pkg::CMD_DEQ && !stat.empty) begin
            state_next = cqs_pkg::S_DEQ;
          end else if (cqs_pkg::cmd_t'(cmd) == cqs_pkg::CMD_SRCH && !stat.empty) begin
            state_next = cqs_pkg::S_SCAN;
          end
        end
      end
      cqs_pkg::S_DEQ: begin
        state_next = cqs_pkg::S_IDLE;
      end
      cqs_pkg::S_SCAN: begin
        if (stat.scan_hit || stat.scan_last) begin
          state_next = cqs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cqs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.ld = cqs_pkg::LD_NONE;
    ctl.st = cqs_pkg::ST_DONE;
    case (state)
      cqs_pkg::S_IDLE: begin
        ctl.in_ready = free;
        if (in_valid && free) begin
          case (cqs_pkg::cmd_t'(cmd))
            cqs_pkg::CMD_ENQ: begin
              ctl.ld = cqs_pkg::LD_SIMPLE;
              if (stat.full) begin
                ctl.st = cqs_pkg::ST_FULL;
              end else begin
                ctl.enq = 1'b1;
              end
            end
            cqs_pkg::CMD_DEQ: begin
              if (stat.empty) begin
                ctl.ld = cqs_pkg::LD_SIMPLE;
                ctl.st = cqs_pkg::ST_EMPTY;
              end else begin
                ctl.deq_rd = 1'b1;
              end
            end
            cqs_pkg::CMD_SRCH: begin
              if (stat.empty) begin
                ctl.ld = cqs_pkg::LD_SIMPLE;
              end else begin
                ctl.srch_start = 1'b1;
              end
            end
            cqs_pkg::CMD_CLR: begin
              ctl.clr = 1'b1;
              ctl.ld  = cqs_pkg::LD_SIMPLE;
            end
            default: begin
              ctl.ld = cqs_pkg::LD_NONE;
            end
          endcase
        end
      end
      cqs_pkg::S_DEQ: begin
        ctl.ld = cqs_pkg::LD_DEQ;
      end
      cqs_pkg::S_SCAN: begin
        ctl.srch_step = 1'b1;
        if (stat.scan_hit || stat.scan_last) begin
          ctl.ld = cqs_pkg::LD_SRCH;
        end
      end
      default: begin
        ctl.ld = cqs_pkg::LD_NONE;
      end
    endcase
  end

  // S_DEQ, where a dequeue waits for the RAM, is entered only after a dequeue read.
  assert property (@(posedge clk) disable iff (rst)
    (state == cqs_pkg::S_DEQ) |-> $past(ctl.deq_rd))
    else $error("dequeue wait state entered without a read");

endmodule

[rtl/cqs_dp.sv]
`timescale 1ns / 1ps

module cqs_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  cqs_pkg::ctl_t                       ctl,
  input  logic signed [cqs_pkg::DATA_W-1:0]   value,
  input  logic                                out_ready,
  output cqs_pkg::dp_stat_t                   stat,
  output logic                                out_valid,
  output logic [1:0]                          status,
  output logic signed [cqs_pkg::DATA_W-1:0]   data,
  output logic                                found,
  output logic [cqs_pkg::CNT_W-1:0]           count
);

  logic [cqs_pkg::IDX_W-1:0]  head;
  logic [cqs_pkg::IDX_W-1:0]  tail;
  logic [cqs_pkg::IDX_W-1:0]  head_next;
  logic [cqs_pkg::IDX_W-1:0]  tail_next;
  logic [cqs_pkg::IDX_W-1:0]  scan_addr;
  logic [cqs_pkg::IDX_W-1:0]  left;
  logic [cqs_pkg::DATA_W-1:0] key;
  logic [cqs_pkg::IDX_W-1:0]  rd_addr;
  logic [cqs_pkg::DATA_W-1:0] rd_data;

  assign head_next = ctl.clr ? '0 : (ctl.deq_rd ? cqs_pkg::next_idx(head) : head);
  assign tail_next = ctl.clr ? '0 : (ctl.enq ? cqs_pkg::next_idx(tail) : tail);
  assign rd_addr   = ctl.srch_step ? scan_addr : head;

  cqs_ram #(
    .WIDTH(cqs_pkg::DATA_W),
    .DEPTH(cqs_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.enq),
    .waddr(tail),
    .wdata(value),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign stat.out_valid = out_valid;
  assign stat.empty     = (head == tail);
  assign stat.full      = (cqs_pkg::next_idx(tail) == head);
  assign stat.scan_hit  = (rd_data == key);
  assign stat.scan_last = (left == cqs_pkg::IDX_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      if (ctl.ld != cqs_pkg::LD_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan pointer runs one slot ahead of the word being compared.
  always_ff @(posedge clk) begin
    if (ctl.srch_start) begin
      key       <= value;
      scan_addr <= cqs_pkg::next_idx(head);
      left      <= cqs_pkg::IDX_W'(cqs_pkg::item_count(head, tail));
    end else if (ctl.srch_step) begin
      scan_addr <= cqs_pkg::next_idx(scan_addr);
      left      <= left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld != cqs_pkg::LD_NONE) begin
      count <= cqs_pkg::item_count(head_next, tail_next);
      case (ctl.ld)
        cqs_pkg::LD_DEQ: begin
          status <= cqs_pkg::ST_DONE;
          data   <= rd_data;
          found  <= 1'b0;
        end
        cqs_pkg::LD_SRCH: begin
          status <= cqs_pkg::ST_DONE;
          data   <= '0;
          found  <= stat.scan_hit;
        end
        default: begin
          status <= ctl.st;
          data   <= '0;
          found  <= 1'b0;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (ctl.ld != cqs_pkg::LD_NONE) |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  assert property (@(posedge clk) disable iff (rst)
    ctl.srch_step |-> (left != '0))
    else $error("search stepped past the occupied entries");

  assert property (@(posedge clk) disable iff (rst)
    ctl.enq |-> !stat.full)
    else $error("write into a full ring");

endmodule
